// File: hw/rtl/sfpf_pkg.sv
// sfpf_pkg: shared types and constants for the prefix-function string builder.
// Holds the item structs, status codes and alphabet constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfpf_pkg;

    // Alphabet size and the code of the first letter
    localparam int unsigned ALPHABET = 26;
    localparam logic [4:0]  LETTER_A = 5'd0;
    localparam logic [4:0]  LETTER_Z = 5'd25;

    // Field widths fixed by the item format
    localparam int unsigned VAL_W = 10;
    localparam int unsigned LET_W = 5;
    localparam int unsigned POS_W = 10;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BIG    = 2'd1,
        ST_NOFREE = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic [VAL_W-1:0] pf_value;
        logic             start_of_string;
    } t_in_item;

    typedef struct packed {
        logic [LET_W-1:0] letter;
        t_status          status;
        logic [POS_W-1:0] position;
    } t_out_item;

    typedef logic [ALPHABET-1:0] t_barred;

endpackage

`default_nettype wire

// File: hw/rtl/sfpf_stream_if.sv
// sfpf_stream_if: valid/ready channel carrying one payload per transfer.
// Payload type is a parameter; used with the structs of sfpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sfpf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sfpf_ram.sv
// sfpf_ram: generic single-write, single-read synchronous RAM.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sfpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sfpf_pick.sv
// sfpf_pick: picks the lowest free letter from 'b' upward.
// Depends on sfpf_pkg for the alphabet constants.
`timescale 1ns / 1ps
`default_nettype none

module sfpf_pick (
    input  wire sfpf_pkg::t_barred i_barred,
    output logic [4:0]             o_letter,
    output logic                   o_found
);

    // priority encoder over 'b'..'z', lowest index wins
    always_comb begin
        o_letter = sfpf_pkg::LETTER_A;
        o_found  = 1'b0;
        for (int k = sfpf_pkg::ALPHABET - 1; k >= 1; k--) begin
            if (!i_barred[k]) begin
                o_letter = 5'(k);
                o_found  = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/string_from_prefix_function.sv
// string_from_prefix_function: top level, sequencer around the value and letter RAMs.
// Depends on sfpf_pkg, sfpf_stream_if, sfpf_ram and sfpf_pick.
//
// Takes one prefix-function value per input transfer and returns one letter per
// output transfer, building the lexicographically smallest string over 'a'..'z'.
// start_of_string restarts the string at position 0. An item that is the first of
// a string, is flagged, or carries a nonzero value passes through the accepting
// state S_IDLE, the evaluation state S_HEAD and the write-back state S_DONE, from
// which its result moves into the output register. A zero value walks the prefix
// chain from S_HEAD on through S_WALK, one link per cycle (each link
// needs one read of the value RAM and one of the letter RAM). Chain walks are
// amortized linear over a string. The next item is accepted in the cycle after the
// result has moved into the output register, even if it is not yet taken. While an
// untaken result sits in the output register, the write-back cycle waits and the
// item stretches. Values and letters live in two MAX_LEN-deep RAMs that need no
// clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module string_from_prefix_function #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sfpf_stream_if.sink   i_in,
    sfpf_stream_if.source o_out
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = (LW > sfpf_pkg::VAL_W) ? LW : sfpf_pkg::VAL_W;
    localparam int VW = sfpf_pkg::VAL_W;
    localparam int XW = sfpf_pkg::LET_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HEAD = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [LW-1:0]       r_len, n_len;
    logic [LW-1:0]       r_pos, n_pos;
    logic [VW-1:0]       r_v, n_v;
    sfpf_pkg::t_barred   r_barred, n_barred;
    logic [XW-1:0]       r_res_letter, n_res_letter;
    sfpf_pkg::t_status   r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    sfpf_pkg::t_out_item r_out_data, n_out_data;

    // RAM ports
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_val_raddr, w_let_raddr;
    logic [VW-1:0] w_val_rdata;
    logic [XW-1:0] w_let_rdata;

    // chain step signals
    sfpf_pkg::t_barred w_cur_barred;
    logic              w_cont;
    logic [XW-1:0]     w_pick_letter;
    logic              w_pick_found;
    logic              w_accept, w_can_out;
    logic [LW-1:0]     w_in_pos;
    logic [VW-1:0]     w_in_vm1;

    sfpf_ram #(.WIDTH(VW), .DEPTH(MAX_LEN)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_v),
        .i_re    (w_re),
        .i_raddr (w_val_raddr),
        .o_rdata (w_val_rdata)
    );

    sfpf_ram #(.WIDTH(XW), .DEPTH(MAX_LEN)) u_let_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_res_letter),
        .i_re    (w_re),
        .i_raddr (w_let_raddr),
        .o_rdata (w_let_rdata)
    );

    sfpf_pick u_pick (
        .i_barred (w_cur_barred),
        .o_letter (w_pick_letter),
        .o_found  (w_pick_found)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    assign w_accept  = i_in.valid && (r_state == S_IDLE);
    assign w_can_out = !r_out_valid || o_out.ready;
    assign w_in_pos  = i_in.data.start_of_string ? '0 : r_len;
    assign w_in_vm1  = i_in.data.pf_value - VW'(1);

    // barred set after this chain link; 'a' is always barred
    always_comb begin
        if (r_state == S_HEAD) begin
            w_cur_barred = sfpf_pkg::t_barred'(1);
        end else begin
            w_cur_barred = r_barred | (sfpf_pkg::t_barred'(1) << w_let_rdata);
        end
        w_cont = (w_val_rdata != '0) && (CW'(w_val_rdata) < CW'(r_pos));
    end

    // sequencer: accept, evaluate/walk, write back and hand off the result
    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_pos        = r_pos;
        n_v          = r_v;
        n_barred     = r_barred;
        n_res_letter = r_res_letter;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_data   = r_out_data;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_waddr      = AW'(r_pos);
        w_val_raddr  = AW'(w_val_rdata - VW'(1));
        w_let_raddr  = AW'(w_val_rdata);

        unique case (r_state)
            S_IDLE: begin
                // issue both candidate reads: copy source and previous value
                w_val_raddr = AW'(w_in_pos - LW'(1));
                w_let_raddr = AW'(w_in_vm1);
                if (w_accept) begin
                    w_re    = 1'b1;
                    n_pos   = w_in_pos;
                    n_v     = i_in.data.pf_value;
                    n_state = S_HEAD;
                    if (i_in.data.start_of_string) begin
                        n_len = '0;
                    end
                end
            end
            S_HEAD, S_WALK: begin
                n_res_letter = sfpf_pkg::LETTER_A;
                n_res_status = sfpf_pkg::ST_OK;
                n_state      = S_DONE;
                if ((r_state == S_HEAD) && (r_pos >= LW'(MAX_LEN))) begin
                    n_res_status = sfpf_pkg::ST_FULL;
                end else if ((r_state == S_HEAD) && (r_pos == '0)) begin
                    n_v = '0;
                end else if ((r_state == S_HEAD) && (CW'(r_v) > CW'(r_pos))) begin
                    n_res_status = sfpf_pkg::ST_BIG;
                end else if ((r_state == S_HEAD) && (r_v != '0)) begin
                    n_res_letter = w_let_rdata;
                end else begin
                    // zero value: follow the chain one link per cycle
                    n_barred = w_cur_barred;
                    if (w_cont) begin
                        w_re    = 1'b1;
                        n_state = S_WALK;
                    end else if (w_pick_found) begin
                        n_res_letter = w_pick_letter;
                    end else begin
                        n_res_status = sfpf_pkg::ST_NOFREE;
                    end
                end
            end
            S_DONE: begin
                if (w_can_out) begin
                    if (r_res_status == sfpf_pkg::ST_OK) begin
                        w_we  = 1'b1;
                        n_len = r_pos + LW'(1);
                    end
                    n_out_valid         = 1'b1;
                    n_out_data.letter   = r_res_letter;
                    n_out_data.status   = r_res_status;
                    n_out_data.position = sfpf_pkg::POS_W'(r_pos);
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_v          <= n_v;
        r_barred     <= n_barred;
        r_res_letter <= n_res_letter;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
    end

    // a stored string never grows past the RAM depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_LEN))
        else $error("length count beyond RAM depth");

    // reads and write-back never share a cycle, so no same-entry overlap
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("RAM read and write in the same cycle");

    // an accepted item always moves on to evaluation
    a_accept_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_HEAD))
        else $error("accepted item not evaluated");

    // a successful result always carries a real letter
    a_ok_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.status == sfpf_pkg::ST_OK))
            |-> (r_out_data.letter <= sfpf_pkg::LETTER_Z))
        else $error("letter out of alphabet");

    // a flagged result stores nothing and reports letter 'a'
    a_err_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.status != sfpf_pkg::ST_OK))
            |-> (r_out_data.letter == sfpf_pkg::LETTER_A))
        else $error("flagged result with nonzero letter");

endmodule

`default_nettype wire
